### design/h2n_pkg.sv
// ----------------------------------------------------------------------------
// Height to normal map: shared package
// Field widths, fixed-point constants and the request type of the shared
// multiply and clamp unit.
// ----------------------------------------------------------------------------
package h2n_pkg;

   localparam int SIZE_BITS_DEFAULT = 7;

   localparam int COORD_W  = 7;
   localparam int HEIGHT_W = 24;
   localparam int PIXEL_W  = 32;
   localparam int CODE_W   = 8;

   // Fixed point: heights carry 2^-20 units per LSB.
   localparam int FRAC_BITS   = 20;
   localparam int DIFF_GAIN   = 25500;
   localparam int HEIGHT_GAIN = 1275;
   localparam int CODE_BIAS   = 128;

   // The operand is a difference or a negated height: one bit wider than a height.
   localparam int OPND_W = HEIGHT_W + 1;
   localparam int GAIN_W = 16;

   typedef enum logic {
      GAIN_DIFF   = 1'b0,
      GAIN_HEIGHT = 1'b1
   } gain_sel_type;

   typedef struct packed {
      logic                      go;
      gain_sel_type              gain_sel;
      logic signed [OPND_W-1:0]  operand;
   } alu_req_type;

endpackage

### design/h2n_req_if.sv
// ----------------------------------------------------------------------------
// Height to normal map: request channel
// Valid/ready channel carrying one write or read item.
// ----------------------------------------------------------------------------
interface h2n_req_if;

   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [h2n_pkg::COORD_W-1:0]         col;
   logic [h2n_pkg::COORD_W-1:0]         row;
   logic signed [h2n_pkg::HEIGHT_W-1:0] height_sample;

   modport source (output valid, mode, col, row, height_sample, input ready);
   modport sink   (input valid, mode, col, row, height_sample, output ready);

endinterface

### design/h2n_rsp_if.sv
// ----------------------------------------------------------------------------
// Height to normal map: response channel
// Valid/ready channel carrying one packed pixel and its coordinates.
// ----------------------------------------------------------------------------
interface h2n_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [h2n_pkg::PIXEL_W-1:0]  pixel_word;
   logic [h2n_pkg::COORD_W-1:0]  out_col;
   logic [h2n_pkg::COORD_W-1:0]  out_row;

   modport source (output valid, pixel_word, out_col, out_row, input ready);
   modport sink   (input valid, pixel_word, out_col, out_row, output ready);

endinterface

### design/h2n_store.sv
// ----------------------------------------------------------------------------
// Height to normal map: height store
// Single-port memory with registered read data, read-before-write.
// ----------------------------------------------------------------------------
module h2n_store #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata_ff
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule

### design/h2n_alu.sv
// ----------------------------------------------------------------------------
// Height to normal map: shared code unit
// Multiplies an operand by the selected gain, registers the product, and
// turns it into a saturated byte code.
// ----------------------------------------------------------------------------
module h2n_alu (
   input  logic                           clock,
   input  h2n_pkg::alu_req_type           alu_req,
   output logic [h2n_pkg::CODE_W-1:0]     code
);

   localparam int PROD_W = h2n_pkg::OPND_W + h2n_pkg::GAIN_W;
   localparam int QUOT_W = PROD_W - h2n_pkg::FRAC_BITS;
   localparam int SUM_W  = QUOT_W + 1;

   logic signed [h2n_pkg::GAIN_W-1:0] gain;
   logic signed [PROD_W-1:0]          product_in;
   logic signed [PROD_W-1:0]          product_ff;
   logic signed [QUOT_W-1:0]          quot;
   logic signed [SUM_W-1:0]           biased;

   always_comb begin
      gain = (alu_req.gain_sel == h2n_pkg::GAIN_DIFF) ?
             h2n_pkg::GAIN_W'(h2n_pkg::DIFF_GAIN) :
             h2n_pkg::GAIN_W'(h2n_pkg::HEIGHT_GAIN);
      product_in = PROD_W'(alu_req.operand) * PROD_W'(gain);
   end

   // The product holds until the next request, so a stalled result stays put.
   always_ff @(posedge clock) begin
      if (alu_req.go) begin
         product_ff <= product_in;
      end
   end

   always_comb begin
      // Arithmetic shift gives the floor of the division by 2^20.
      quot   = $signed(product_ff[PROD_W-1:h2n_pkg::FRAC_BITS]);
      biased = SUM_W'(quot) + SUM_W'(h2n_pkg::CODE_BIAS);
      if (biased < 0) begin
         code = '0;
      end else if (biased > SUM_W'(255)) begin
         code = '1;
      end else begin
         code = biased[h2n_pkg::CODE_W-1:0];
      end
   end

endmodule

### design/height_to_normal_map_unit.sv
// ----------------------------------------------------------------------------
// Height to normal map unit
// Toroidal height field with a sequencer that builds packed normal-map
// pixels from central differences through one shared multiply unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries items. mode 0 writes height_sample at (col, row) and
//   gives no response; mode 1 reads the pixel at (col, row), which returns on
//   rsp_chan with its masked coordinates. Coordinates are reduced modulo the
//   field size, and neighbours wrap at the edges.
//   A write passes through S_WR, which writes the store, before the next
//   request is taken. A read steps through S_RE, S_RW, S_RS, S_RN, S_RC,
//   S_RH and S_RD: five reads of the single-port height store, one a
//   cycle, overlapped with the shared multiplier that codes dx, dy and the
//   height in turn. The response register is loaded in the last step, S_RD.
//   The response sits in an output register: new requests are taken while
//   it waits. If the receiver stalls and a second read finishes, the
//   sequencer holds in its final step until the register is free.
//   Reset clears the sequencer and the response valid; the height store is
//   not cleared, and every entry must be written before it is read.
// ----------------------------------------------------------------------------
module height_to_normal_map_unit #(
   parameter int SIZE_BITS = h2n_pkg::SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   h2n_req_if.sink    req_chan,
   h2n_rsp_if.source  rsp_chan
);

   localparam int ADDR_W = 2 * SIZE_BITS;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_WR   = 9'b000000010,
      S_RE   = 9'b000000100,
      S_RW   = 9'b000001000,
      S_RS   = 9'b000010000,
      S_RN   = 9'b000100000,
      S_RC   = 9'b001000000,
      S_RH   = 9'b010000000,
      S_RD   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_BITS-1:0]               col_ff, row_ff;
   logic [h2n_pkg::HEIGHT_W-1:0]       height_ff;
   logic [h2n_pkg::HEIGHT_W-1:0]       hold_ff;
   logic [h2n_pkg::CODE_W-1:0]         dx_code_ff, dy_code_ff;

   logic                               rsp_valid_ff;
   logic [h2n_pkg::PIXEL_W-1:0]        pixel_ff;
   logic [h2n_pkg::COORD_W-1:0]        out_col_ff, out_row_ff;

   logic                               store_we;
   logic [ADDR_W-1:0]                  store_addr;
   logic [h2n_pkg::HEIGHT_W-1:0]       store_q;

   h2n_pkg::alu_req_type               alu_req;
   logic [h2n_pkg::CODE_W-1:0]         code;

   logic                               req_xfer;
   logic                               out_free;
   logic signed [h2n_pkg::OPND_W-1:0]  hold_ext, q_ext;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign hold_ext = $signed({hold_ff[h2n_pkg::HEIGHT_W-1], hold_ff});
   assign q_ext    = $signed({store_q[h2n_pkg::HEIGHT_W-1], store_q});

   h2n_store #(
      .ADDR_W (ADDR_W),
      .DATA_W (h2n_pkg::HEIGHT_W)
   ) u_store (
      .clock    (clock),
      .we       (store_we),
      .addr     (store_addr),
      .wdata    (height_ff),
      .rdata_ff (store_q)
   );

   h2n_alu u_alu (
      .clock   (clock),
      .alu_req (alu_req),
      .code    (code)
   );

   // Sequencer: next state, store address and shared unit requests.
   always_comb begin
      state_in         = state_ff;
      store_we         = 1'b0;
      store_addr       = {row_ff, col_ff};
      alu_req.go       = 1'b0;
      alu_req.gain_sel = h2n_pkg::GAIN_DIFF;
      alu_req.operand  = hold_ext - q_ext;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = req_chan.mode ? S_RE : S_WR;
            end
         end
         S_WR: begin
            store_we = 1'b1;
            state_in = S_IDLE;
         end
         S_RE: begin
            store_addr = {row_ff, SIZE_BITS'(col_ff + 1'b1)};
            state_in   = S_RW;
         end
         S_RW: begin
            store_addr = {row_ff, SIZE_BITS'(col_ff - 1'b1)};
            state_in   = S_RS;
         end
         S_RS: begin
            store_addr = {SIZE_BITS'(row_ff + 1'b1), col_ff};
            alu_req.go = 1'b1;
            state_in   = S_RN;
         end
         S_RN: begin
            store_addr = {SIZE_BITS'(row_ff - 1'b1), col_ff};
            state_in   = S_RC;
         end
         S_RC: begin
            alu_req.go = 1'b1;
            state_in   = S_RH;
         end
         S_RH: begin
            alu_req.go       = 1'b1;
            alu_req.gain_sel = h2n_pkg::GAIN_HEIGHT;
            alu_req.operand  = h2n_pkg::OPND_W'(0) - q_ext;
            state_in         = S_RD;
         end
         S_RD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         col_ff    <= SIZE_BITS'(req_chan.col);
         row_ff    <= SIZE_BITS'(req_chan.row);
         height_ff <= req_chan.height_sample;
      end
      // The right and lower neighbours wait here for their partners.
      if (state_ff == S_RW || state_ff == S_RN) begin
         hold_ff <= store_q;
      end
      if (state_ff == S_RN) begin
         dx_code_ff <= code;
      end
      if (state_ff == S_RH) begin
         dy_code_ff <= code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_RD && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RD && out_free) begin
         pixel_ff   <= {code, dx_code_ff, dy_code_ff, 8'hFF};
         out_col_ff <= h2n_pkg::COORD_W'(col_ff);
         out_row_ff <= h2n_pkg::COORD_W'(row_ff);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pixel_word = pixel_ff;
   assign rsp_chan.out_col    = out_col_ff;
   assign rsp_chan.out_row    = out_row_ff;

   // A read transfer keeps the request side closed in the following cycle.
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.mode) |=> !req_chan.ready)
      else $error("request taken during a read sequence");

   // Finishing a read with the output free always presents a response.
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && out_free) |=> rsp_valid_ff)
      else $error("finished read did not load the response");

   // A write transfer never raises a response.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_chan.mode) |=> !$rose(rsp_valid_ff))
      else $error("response raised after a write");

endmodule
